FILE: rtl/frame_pool_free_list_allocator_assert.svh
// Assertion macros shared by the frame pool allocator RTL.
`ifndef FRAME_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FRAME_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Expression must hold at every clock edge out of reset.
`define FPA_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fpa: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpa: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpa: next-cycle check violated");

`endif

FILE: rtl/fpa_pkg.sv
// Shared constants and types for the frame pool allocator.
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int POOL_MAX_DEF = 64;

    localparam int FUNC_W     = 1;
    localparam int IDX_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int LEFT_W     = 8;
    localparam int CEIL_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CEIL_W-1:0] CEIL_RESET = 7'd64;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } t_status;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_CEILING  = 1'b0,
        CFG_NOTIFY_ENABLE = 1'b1
    } t_cfg_reg;

endpackage

FILE: rtl/fpa_ifs.sv
// Request and response channel interfaces of the frame pool allocator.
`timescale 1ns / 1ps

interface fpa_req_if;
    logic                        valid;
    logic                        ready;
    logic [fpa_pkg::FUNC_W-1:0]  func;
    logic [fpa_pkg::IDX_W-1:0]   frame_index;

    modport source (output valid, output func, output frame_index, input ready);
    modport sink   (input valid, input func, input frame_index, output ready);
endinterface

interface fpa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [fpa_pkg::STATUS_W-1:0]      status;
    logic [fpa_pkg::IDX_W-1:0]         granted_index;
    logic signed [fpa_pkg::LEFT_W-1:0] frames_left;
    logic                              have_free_pulse;

    modport source (output valid, output status, output granted_index,
                    output frames_left, output have_free_pulse, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input frames_left, input have_free_pulse, output ready);
endinterface

FILE: rtl/frame_pool_free_list_allocator.sv
// Frame pool allocator: free-queue reuse, fresh index creation, return checking.
// Results are registered: a result is shown in the cycle after its item is accepted (output register).
// Throughput: one item per cycle; the output register lets a new item in while the
//   previous result is taken, so only a stalled result holds the request side.
// Reset (synchronous, active low): counters, queue pointers and allocation map clear,
//   pool_ceiling returns to 64, notify_enable to 0; the free-queue memory is not cleared.
`timescale 1ns / 1ps
`include "frame_pool_free_list_allocator_assert.svh"

module frame_pool_free_list_allocator #(
    parameter int POOL_MAX = fpa_pkg::POOL_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    fpa_req_if.sink                          i_req,
    fpa_rsp_if.source                        o_rsp
);

    // Frame id width, count width (must hold POOL_MAX itself).
    localparam int IW  = $clog2(POOL_MAX);
    localparam int CW  = $clog2(POOL_MAX + 1);
    // Widths for range checks on the 6-bit request index and the granted index.
    localparam int XW  = ((IW > fpa_pkg::IDX_W) ? IW : fpa_pkg::IDX_W) + 1;
    localparam int GXW = (IW > fpa_pkg::IDX_W) ? IW : fpa_pkg::IDX_W;
    // Ceiling arithmetic width, and signed difference width.
    localparam int EW  = ((CW > fpa_pkg::CEIL_W) ? CW : fpa_pkg::CEIL_W) + 1;
    localparam int DW  = EW + 1;

    localparam logic signed [DW-1:0] LEFT_MAX = DW'(127);
    localparam logic signed [DW-1:0] LEFT_MIN = -DW'(128);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fpa_pkg::CEIL_W-1:0] r_ceiling;
    logic                       r_notify;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= fpa_pkg::CEIL_RESET;
            r_notify  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (fpa_pkg::t_cfg_reg'(i_cfg_idx))
                fpa_pkg::CFG_POOL_CEILING:  r_ceiling <= i_cfg_data;
                fpa_pkg::CFG_NOTIFY_ENABLE: r_notify  <= i_cfg_data[0];
            endcase
        end
    end

    // A ceiling above the pool size acts as the pool size.
    logic [EW-1:0] ceil_x;
    logic [EW-1:0] eff_ceiling;

    assign ceil_x      = EW'(r_ceiling);
    assign eff_ceiling = (ceil_x > EW'(POOL_MAX)) ? EW'(POOL_MAX) : ceil_x;

    // ------------------------------------------------------------------
    // Pool state
    // ------------------------------------------------------------------
    logic [POOL_MAX-1:0] r_map;        // one bit per allocated frame
    logic [CW-1:0]       r_alloc_cnt;
    logic [CW-1:0]       r_created;
    logic [CW-1:0]       r_q_cnt;
    logic [IW-1:0]       r_head;
    logic [IW-1:0]       r_tail;

    logic [POOL_MAX-1:0] n_map;
    logic [CW-1:0]       n_alloc_cnt;
    logic [CW-1:0]       n_created;
    logic [CW-1:0]       n_q_cnt;
    logic [IW-1:0]       n_head;
    logic [IW-1:0]       n_tail;

    // Free queue memory, with the head entry prefetched into a register.
    logic [IW-1:0]       r_queue_mem [POOL_MAX];
    logic [IW-1:0]       r_rd_data;
    logic                r_byp;
    logic [IW-1:0]       r_byp_data;
    logic [IW-1:0]       head_data;
    logic [IW-1:0]       head_inc;
    logic [IW-1:0]       tail_inc;
    logic [IW-1:0]       rd_addr;

    // Output register
    logic                          r_out_valid;
    fpa_pkg::t_status              r_status;
    logic [fpa_pkg::IDX_W-1:0]     r_granted;
    logic signed [fpa_pkg::LEFT_W-1:0] r_left;
    logic                          r_pulse;

    // Per-item decode
    logic                          accept;
    logic [XW-1:0]                 idx_x;
    logic                          idx_in_range;
    logic [IW-1:0]                 idx_b;
    logic                          q_empty;
    logic                          q_full;
    logic                          exhausted;
    logic                          pop;
    logic                          push;
    fpa_pkg::t_status              status;
    logic [IW-1:0]                 granted;
    logic [GXW-1:0]                granted_x;
    logic                          pulse;
    logic signed [DW-1:0]          left_diff;
    logic signed [fpa_pkg::LEFT_W-1:0] left_sat;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign idx_x        = XW'(i_req.frame_index);
    assign idx_in_range = idx_x < XW'(POOL_MAX);
    assign idx_b        = idx_x[IW-1:0];

    assign q_empty   = (r_q_cnt == '0);
    assign q_full    = (r_q_cnt == CW'(POOL_MAX));
    assign exhausted = (EW'(r_created) >= eff_ceiling);

    assign head_data = r_byp ? r_byp_data : r_rd_data;
    assign head_inc  = (r_head == IW'(POOL_MAX - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc  = (r_tail == IW'(POOL_MAX - 1)) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_map       = r_map;
        n_alloc_cnt = r_alloc_cnt;
        n_created   = r_created;
        n_q_cnt     = r_q_cnt;
        n_head      = r_head;
        n_tail      = r_tail;
        status      = fpa_pkg::ST_OK;
        granted     = '0;
        pulse       = 1'b0;
        pop         = 1'b0;
        push        = 1'b0;

        if (fpa_pkg::t_func'(i_req.func) == fpa_pkg::FN_ALLOC) begin
            // Oldest returned frame first, else a fresh index below the ceiling.
            if (!q_empty) begin
                granted = head_data;
                pop     = 1'b1;
                n_head  = head_inc;
                n_q_cnt = r_q_cnt - 1'b1;
            end else if (exhausted) begin
                status = fpa_pkg::ST_EXHAUSTED;
            end else begin
                granted   = r_created[IW-1:0];
                n_created = r_created + 1'b1;
            end
            if (status == fpa_pkg::ST_OK) begin
                n_map[granted] = 1'b1;
                n_alloc_cnt    = r_alloc_cnt + 1'b1;
            end
        end else begin
            if (!idx_in_range || !r_map[idx_b] || q_full) begin
                status = fpa_pkg::ST_NOT_ALLOC;
            end else begin
                n_map[idx_b] = 1'b0;
                n_alloc_cnt  = r_alloc_cnt - 1'b1;
                pulse        = q_empty && r_notify;
                push         = 1'b1;
                n_tail       = tail_inc;
                n_q_cnt      = r_q_cnt + 1'b1;
            end
        end
    end

    // Frames left after this item, saturated to the 8-bit signed field.
    assign left_diff = $signed({1'b0, eff_ceiling}) - $signed({1'b0, EW'(n_alloc_cnt)});

    always_comb begin
        priority if (left_diff > LEFT_MAX) begin
            left_sat = fpa_pkg::LEFT_W'(LEFT_MAX);
        end else if (left_diff < LEFT_MIN) begin
            left_sat = fpa_pkg::LEFT_W'(LEFT_MIN);
        end else begin
            left_sat = left_diff[fpa_pkg::LEFT_W-1:0];
        end
    end

    assign granted_x = GXW'(granted);

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map       <= '0;
            r_alloc_cnt <= '0;
            r_created   <= '0;
            r_q_cnt     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
        end else if (accept) begin
            r_map       <= n_map;
            r_alloc_cnt <= n_alloc_cnt;
            r_created   <= n_created;
            r_q_cnt     <= n_q_cnt;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    // Queue memory: one write at the tail, one registered read of the next head.
    // A write landing on the address being read is forwarded for one cycle.
    assign rd_addr = (accept && pop) ? head_inc : r_head;

    always_ff @(posedge i_clk) begin
        if (accept && push) begin
            r_queue_mem[r_tail] <= idx_b;
        end
        r_rd_data  <= r_queue_mem[rd_addr];
        r_byp_data <= idx_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= accept && push && (r_tail == rd_addr);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= status;
            r_granted <= granted_x[fpa_pkg::IDX_W-1:0];
            r_left    <= left_sat;
            r_pulse   <= pulse;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.granted_index   = r_granted;
    assign o_rsp.frames_left     = r_left;
    assign o_rsp.have_free_pulse = r_pulse;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // Allocated count tracks the map.
    `FPA_ASSERT_ALWAYS(a_alloc_cnt_map, i_clk, i_rst_n,
        $countones(r_map) == 32'(r_alloc_cnt))
    // Every frame ever made is either held by a user or waiting in the queue.
    `FPA_ASSERT_ALWAYS(a_created_split, i_clk, i_rst_n,
        {1'b0, r_created} == ({1'b0, r_alloc_cnt} + {1'b0, r_q_cnt}))
    // Notify only accompanies a successful return.
    `FPA_ASSERT_IMP(a_pulse_ok, i_clk, i_rst_n,
        r_out_valid && r_pulse, r_status == fpa_pkg::ST_OK)
    // Every accepted item produces a result in the next cycle.
    `FPA_ASSERT_NEXT(a_accept_result, i_clk, i_rst_n, accept, r_out_valid)

endmodule
